[hdl/fdt_pkg.sv]
// fdt_pkg: shared constants, codes and types of the fault debounce table
package fdt_pkg;

   localparam int CHANNELS_DEF = 16;
   localparam int TYPES        = 3;
   localparam int CODE_W       = 3;
   localparam int TIME_W       = 8;
   localparam int OP_W         = 3;
   localparam int CH_IN_W      = 4;
   localparam int KIND_W       = 2;
   localparam int TYPE_W       = 2;
   localparam int CFG_IDX_W    = 3;
   localparam int CFG_DATA_W   = 8;
   localparam int CODES_W      = TYPES * CODE_W;
   localparam int CNT_W        = TYPES * 2 * TIME_W;

   localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
   localparam logic [OP_W-1:0] OP_REPORT    = 3'd1;
   localparam logic [OP_W-1:0] OP_ENABLE    = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR     = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR_ALL = 3'd4;
   localparam logic [OP_W-1:0] OP_QUERY     = 3'd5;

   localparam logic [CODE_W-1:0] CODE_POS  = 3'd0;
   localparam logic [CODE_W-1:0] CODE_NEG  = 3'd1;
   localparam logic [CODE_W-1:0] CODE_SET  = 3'd2;
   localparam logic [CODE_W-1:0] CODE_CLR  = 3'd3;
   localparam logic [CODE_W-1:0] CODE_IDLE = 3'd4;

   localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FAIL  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PASS  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd3;

   localparam logic [TYPE_W-1:0] TYPE_VCC  = 2'd0;
   localparam logic [TYPE_W-1:0] TYPE_GND  = 2'd1;
   localparam logic [TYPE_W-1:0] TYPE_OPEN = 2'd2;

   localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_EN = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_VCC_SET   = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_VCC_CLR   = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CFG_GND_SET   = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CFG_GND_CLR   = 3'd4;
   localparam logic [CFG_IDX_W-1:0] CFG_OPEN_SET  = 3'd5;
   localparam logic [CFG_IDX_W-1:0] CFG_OPEN_CLR  = 3'd6;
   localparam logic [CFG_IDX_W-1:0] CFG_MASK      = 3'd7;

   typedef logic [TYPES-1:0][TIME_W-1:0] times_type;

   typedef struct packed {
      logic [CNT_W-1:0] cnt;
      logic [TYPES-1:0] ev;
      logic [TYPES-1:0] fail;
      logic [TYPES-1:0] fbits;
      logic             icpt;
   } eval_type;

endpackage

[hdl/fault_debounce_table.sv]
// fault_debounce_table: top level, command decode, tick walk and result output
// A tick walks channels 1 to CHANNELS-1: a disabled channel only passes S_RD, an
// enabled one passes S_RD (code and counter ram read), then S_PROC (debounce and
// write-back) and an S_EMIT step for each report it raises, and the walk ends in
// the closing S_DONE state, with busy held high throughout; with global enable clear
// a tick is dropped in its accept cycle with busy staying low. Reports leave at most
// one per cycle, delayed by one slot so that the final one carries last; a tick
// with nothing to report gives no result.
// Every other operation completes in the accept cycle and its single result
// shows on the next cycle with busy staying low. Results are strobed by rsp_valid
// for one cycle each and cannot be held off, so the receiver must take every one.
module fault_debounce_table #(
   parameter int CHANNELS = fdt_pkg::CHANNELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [fdt_pkg::OP_W-1:0]        req_op,
   input  logic [fdt_pkg::CH_IN_W-1:0]     req_channel,
   input  logic [fdt_pkg::CODE_W-1:0]      req_open_code,
   input  logic [fdt_pkg::CODE_W-1:0]      req_vcc_code,
   input  logic [fdt_pkg::CODE_W-1:0]      req_gnd_code,
   input  logic                            req_enable_flag,
   input  logic [fdt_pkg::TYPE_W-1:0]      req_query_type,
   output logic                            rsp_valid,
   output logic [fdt_pkg::KIND_W-1:0]      rsp_kind,
   output logic [fdt_pkg::CH_IN_W-1:0]     rsp_out_channel,
   output logic [fdt_pkg::TYPE_W-1:0]      rsp_out_type,
   output logic                            rsp_fault_bit,
   output logic [fdt_pkg::TYPES-1:0]       rsp_fault_bits,
   output logic                            rsp_intercept,
   output logic                            rsp_last,
   input  logic                            csr_we,
   input  logic [fdt_pkg::CFG_IDX_W-1:0]   csr_index,
   input  logic [fdt_pkg::CFG_DATA_W-1:0]  csr_wdata
);

   import fdt_pkg::*;

   localparam int CH_W  = $clog2(CHANNELS);
   localparam int CHV_W = CH_IN_W + 1;
   localparam logic [CHV_W-1:0] CH_LIMIT = CHV_W'(CHANNELS);
   localparam logic [CH_W-1:0]  LAST_CH  = CH_W'(CHANNELS - 1);
   localparam logic [CH_W-1:0]  FIRST_CH = CH_W'(1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_PROC = 3'd2;
   localparam logic [2:0] S_EMIT = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   // configuration
   logic              gen_ff;
   times_type         set_time_ff;
   times_type         clr_time_ff;
   logic [TYPES-1:0]  mask_ff;

   // per channel state in flops
   logic [TYPES-1:0]    fault_ff [CHANNELS];
   logic                icptf_ff [CHANNELS];
   logic [CHANNELS-1:0] en_ff;
   logic [CHANNELS-1:0] code_vld_ff;
   logic [CHANNELS-1:0] cnt_vld_ff;
   logic [CODE_W-1:0]   dflt_code_ff;
   logic                code_vld_rd_ff;
   logic                cnt_vld_rd_ff;

   // walk control
   logic [2:0]       state_ff,  state_in;
   logic [CH_W-1:0]  ch_ff,     ch_in;
   logic [TYPES-1:0] pend_ff,   pend_in;
   logic [TYPES-1:0] fail_ff,   fail_in;
   logic [TYPES-1:0] fbits_ff,  fbits_in;
   logic             icpt_ff,   icpt_in;

   // one report held back until its successor or the end of the walk is known
   logic               hold_vld_ff,  hold_vld_in;
   logic               hold_fail_ff, hold_fail_in;
   logic [TYPE_W-1:0]  hold_type_ff, hold_type_in;
   logic [CH_IN_W-1:0] hold_ch_ff,   hold_ch_in;
   logic [TYPES-1:0]   hold_bits_ff, hold_bits_in;
   logic               hold_icpt_ff, hold_icpt_in;

   // result registers
   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  rsp_kind_ff,  rsp_kind_in;
   logic [CH_IN_W-1:0] rsp_ch_ff,    rsp_ch_in;
   logic [TYPE_W-1:0]  rsp_type_ff,  rsp_type_in;
   logic               rsp_bit_ff,   rsp_bit_in;
   logic [TYPES-1:0]   rsp_bits_ff,  rsp_bits_in;
   logic               rsp_icpt_ff,  rsp_icpt_in;
   logic               rsp_last_ff,  rsp_last_in;

   logic              accept;
   logic              req_ok;
   logic [CH_W-1:0]   req_idx;
   logic [CH_W-1:0]   rd_idx;
   logic [TYPES-1:0]  cur_bits;
   logic              cur_icpt;
   logic              q_bit;
   logic              code_we;
   logic [CODES_W-1:0] code_rdata;
   logic [CNT_W-1:0]   cnt_rdata;
   logic [CODES_W-1:0] eval_codes;
   logic [CNT_W-1:0]   eval_cnt;
   eval_type           ev;
   logic [TYPE_W-1:0]  sel_type;
   logic               sel_fail;

   assign accept   = start && !busy;
   assign busy     = (state_ff != S_IDLE);
   assign req_ok   = ({1'b0, req_channel} < CH_LIMIT);
   assign req_idx  = req_channel[CH_W-1:0];
   assign rd_idx   = busy ? ch_ff : req_idx;
   assign cur_bits = fault_ff[rd_idx];
   assign cur_icpt = icptf_ff[rd_idx];
   assign code_we  = accept && (req_op == OP_REPORT) && req_ok;

   fdt_ram #(
      .WIDTH (CODES_W),
      .DEPTH (CHANNELS)
   ) u_code_ram (
      .clock (clock),
      .we    (code_we),
      .waddr (req_idx),
      .wdata ({req_open_code, req_gnd_code, req_vcc_code}),
      .raddr (ch_ff),
      .rdata (code_rdata)
   );

   fdt_ram #(
      .WIDTH (CNT_W),
      .DEPTH (CHANNELS)
   ) u_cnt_ram (
      .clock (clock),
      .we    (state_ff == S_PROC),
      .waddr (ch_ff),
      .wdata (ev.cnt),
      .raddr (ch_ff),
      .rdata (cnt_rdata)
   );

   assign eval_codes = code_vld_rd_ff ? code_rdata : {TYPES{dflt_code_ff}};
   assign eval_cnt   = cnt_vld_rd_ff ? cnt_rdata : '0;

   fdt_eval u_eval (
      .codes     (eval_codes),
      .cnt_cur   (eval_cnt),
      .set_time  (set_time_ff),
      .clr_time  (clr_time_ff),
      .fbits_cur (cur_bits),
      .icpt_cur  (cur_icpt),
      .mask      (mask_ff),
      .res       (ev)
   );

   // lowest pending type is reported first
   always_comb begin
      if (pend_ff[0]) begin
         sel_type = TYPE_VCC;
      end else if (pend_ff[1]) begin
         sel_type = TYPE_GND;
      end else begin
         sel_type = TYPE_OPEN;
      end
      sel_fail = fail_ff[sel_type];
   end

   always_comb begin
      case (req_query_type)
         TYPE_VCC:  q_bit = cur_bits[0];
         TYPE_GND:  q_bit = cur_bits[1];
         TYPE_OPEN: q_bit = cur_bits[2];
         default:   q_bit = 1'b0;
      endcase
   end

   always_comb begin
      logic push;
      logic flush;
      push         = 1'b0;
      flush        = 1'b0;
      state_in     = state_ff;
      ch_in        = ch_ff;
      pend_in      = pend_ff;
      fail_in      = fail_ff;
      fbits_in     = fbits_ff;
      icpt_in      = icpt_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_op == OP_TICK) && gen_ff) begin
               ch_in    = FIRST_CH;
               state_in = S_RD;
            end
         end
         S_RD: begin
            if (!en_ff[ch_ff]) begin
               if (ch_ff == LAST_CH) begin
                  state_in = S_DONE;
               end else begin
                  ch_in = ch_ff + 1'b1;
               end
            end else begin
               state_in = S_PROC;
            end
         end
         S_PROC: begin
            pend_in  = ev.ev;
            fail_in  = ev.fail;
            fbits_in = ev.fbits;
            icpt_in  = ev.icpt;
            if (|ev.ev) begin
               state_in = S_EMIT;
            end else if (ch_ff == LAST_CH) begin
               state_in = S_DONE;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_EMIT: begin
            push    = 1'b1;
            pend_in = pend_ff & (pend_ff - 1'b1);
            if (pend_in == '0) begin
               if (ch_ff == LAST_CH) begin
                  state_in = S_DONE;
               end else begin
                  ch_in    = ch_ff + 1'b1;
                  state_in = S_RD;
               end
            end
         end
         S_DONE: begin
            flush    = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      hold_vld_in  = hold_vld_ff;
      hold_fail_in = hold_fail_ff;
      hold_type_in = hold_type_ff;
      hold_ch_in   = hold_ch_ff;
      hold_bits_in = hold_bits_ff;
      hold_icpt_in = hold_icpt_ff;

      rsp_valid_in = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_ch_in    = rsp_ch_ff;
      rsp_type_in  = rsp_type_ff;
      rsp_bit_in   = rsp_bit_ff;
      rsp_bits_in  = rsp_bits_ff;
      rsp_icpt_in  = rsp_icpt_ff;
      rsp_last_in  = rsp_last_ff;

      if ((push || flush) && hold_vld_ff) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = hold_fail_ff ? KIND_FAIL : KIND_PASS;
         rsp_ch_in    = hold_ch_ff;
         rsp_type_in  = hold_type_ff;
         rsp_bit_in   = hold_fail_ff;
         rsp_bits_in  = hold_bits_ff;
         rsp_icpt_in  = hold_icpt_ff;
         rsp_last_in  = flush;
      end
      if (flush) begin
         hold_vld_in = 1'b0;
      end
      if (push) begin
         hold_vld_in  = 1'b1;
         hold_fail_in = sel_fail;
         hold_type_in = sel_type;
         hold_ch_in   = CH_IN_W'(ch_ff);
         hold_bits_in = fbits_ff;
         hold_icpt_in = icpt_ff;
      end

      if (accept && (req_op != OP_TICK)) begin
         rsp_valid_in = 1'b1;
         rsp_ch_in    = req_channel;
         rsp_last_in  = 1'b1;
         if (req_op == OP_QUERY) begin
            rsp_kind_in = KIND_QUERY;
            rsp_type_in = (req_query_type == TYPE_VCC || req_query_type == TYPE_GND ||
                           req_query_type == TYPE_OPEN) ? req_query_type : TYPE_VCC;
            rsp_bit_in  = req_ok && q_bit;
            rsp_bits_in = req_ok ? cur_bits : '0;
            rsp_icpt_in = req_ok && cur_icpt;
         end else begin
            rsp_kind_in = KIND_ACK;
            rsp_type_in = TYPE_VCC;
            rsp_bit_in  = 1'b0;
            rsp_bits_in = '0;
            rsp_icpt_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff      <= 1'b1;
         set_time_ff <= '0;
         clr_time_ff <= '0;
         mask_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CFG_GLOBAL_EN: gen_ff         <= csr_wdata[0];
            CFG_VCC_SET:   set_time_ff[0] <= csr_wdata;
            CFG_VCC_CLR:   clr_time_ff[0] <= csr_wdata;
            CFG_GND_SET:   set_time_ff[1] <= csr_wdata;
            CFG_GND_CLR:   clr_time_ff[1] <= csr_wdata;
            CFG_OPEN_SET:  set_time_ff[2] <= csr_wdata;
            CFG_OPEN_CLR:  clr_time_ff[2] <= csr_wdata;
            CFG_MASK:      mask_ff        <= csr_wdata[TYPES-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            fault_ff[i] <= '0;
            icptf_ff[i] <= 1'b0;
            en_ff[i]    <= (i != 0);
         end
         code_vld_ff  <= '0;
         cnt_vld_ff   <= '0;
         dflt_code_ff <= CODE_IDLE;
      end else begin
         if (accept) begin
            unique case (req_op)
               OP_REPORT: begin
                  if (req_ok) begin
                     code_vld_ff[req_idx] <= 1'b1;
                  end
               end
               OP_ENABLE: begin
                  if (req_ok) begin
                     en_ff[req_idx] <= req_enable_flag;
                  end
               end
               OP_CLEAR: begin
                  if (req_ok) begin
                     cnt_vld_ff[req_idx] <= 1'b0;
                     fault_ff[req_idx]   <= '0;
                     icptf_ff[req_idx]   <= 1'b0;
                  end
               end
               OP_CLEAR_ALL: begin
                  for (int i = 0; i < CHANNELS; i++) begin
                     fault_ff[i] <= '0;
                     icptf_ff[i] <= 1'b0;
                  end
                  code_vld_ff  <= '0;
                  cnt_vld_ff   <= '0;
                  dflt_code_ff <= CODE_CLR;
               end
               default: ;
            endcase
         end
         if (state_ff == S_PROC) begin
            cnt_vld_ff[ch_ff] <= 1'b1;
            fault_ff[ch_ff]   <= ev.fbits;
            icptf_ff[ch_ff]   <= ev.icpt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hold_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hold_vld_ff  <= hold_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      ch_ff          <= ch_in;
      pend_ff        <= pend_in;
      fail_ff        <= fail_in;
      fbits_ff       <= fbits_in;
      icpt_ff        <= icpt_in;
      code_vld_rd_ff <= code_vld_ff[ch_ff];
      cnt_vld_rd_ff  <= cnt_vld_ff[ch_ff];
      hold_fail_ff   <= hold_fail_in;
      hold_type_ff   <= hold_type_in;
      hold_ch_ff     <= hold_ch_in;
      hold_bits_ff   <= hold_bits_in;
      hold_icpt_ff   <= hold_icpt_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_ch_ff      <= rsp_ch_in;
      rsp_type_ff    <= rsp_type_in;
      rsp_bit_ff     <= rsp_bit_in;
      rsp_bits_ff    <= rsp_bits_in;
      rsp_icpt_ff    <= rsp_icpt_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_out_channel = rsp_ch_ff;
   assign rsp_out_type    = rsp_type_ff;
   assign rsp_fault_bit   = rsp_bit_ff;
   assign rsp_fault_bits  = rsp_bits_ff;
   assign rsp_intercept   = rsp_icpt_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

[hdl/fdt_ram.sv]
// fdt_ram: generic single write port ram with registered read
module fdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hdl/fdt_eval.sv]
// fdt_eval: debounce step of one channel over its three defect types
module fdt_eval (
   input  logic [fdt_pkg::CODES_W-1:0] codes,
   input  logic [fdt_pkg::CNT_W-1:0]   cnt_cur,
   input  fdt_pkg::times_type          set_time,
   input  fdt_pkg::times_type          clr_time,
   input  logic [fdt_pkg::TYPES-1:0]   fbits_cur,
   input  logic                        icpt_cur,
   input  logic [fdt_pkg::TYPES-1:0]   mask,
   output fdt_pkg::eval_type           res
);

   import fdt_pkg::*;

   always_comb begin
      logic [CODE_W-1:0] code;
      logic [TIME_W-1:0] sc;
      logic [TIME_W-1:0] cc;
      logic              evt;
      logic              fl;
      res       = '0;
      res.fbits = fbits_cur;
      for (int t = 0; t < TYPES; t++) begin
         code = codes[t*CODE_W +: CODE_W];
         cc   = cnt_cur[t*2*TIME_W +: TIME_W];
         sc   = cnt_cur[t*2*TIME_W + TIME_W +: TIME_W];
         evt  = 1'b0;
         fl   = 1'b0;
         case (code)
            CODE_POS: begin
               if (sc < set_time[t]) begin
                  sc = sc + 1'b1;
               end else begin
                  evt = 1'b1;
                  fl  = 1'b1;
               end
            end
            CODE_NEG: begin
               if (cc < clr_time[t]) begin
                  cc = cc + 1'b1;
               end else begin
                  evt = 1'b1;
               end
            end
            CODE_SET: begin
               evt = 1'b1;
               fl  = 1'b1;
            end
            CODE_CLR: begin
               evt = 1'b1;
            end
            default: ;
         endcase
         if (evt) begin
            sc           = '0;
            cc           = '0;
            res.fbits[t] = fl;
         end
         res.ev[t]                                = evt;
         res.fail[t]                              = fl;
         res.cnt[t*2*TIME_W +: TIME_W]            = cc;
         res.cnt[t*2*TIME_W + TIME_W +: TIME_W]   = sc;
      end
      res.icpt = icpt_cur | (|(res.fbits & mask));
   end

endmodule

[hdl/fdt_checker.sv]
// fdt_checker: port level assertions of the fault debounce table, bound to the top level
module fdt_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic [fdt_pkg::OP_W-1:0]     req_op,
   input logic [fdt_pkg::CH_IN_W-1:0]  req_channel,
   input logic                         rsp_valid,
   input logic [fdt_pkg::KIND_W-1:0]   rsp_kind,
   input logic [fdt_pkg::CH_IN_W-1:0]  rsp_out_channel,
   input logic                         rsp_last
);

   import fdt_pkg::*;

   // a non-tick transaction answers on the next cycle as a single result
   a_cmd_answer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op != OP_TICK) |=> (rsp_valid && rsp_last && !busy))
      else $error("command transaction not answered on the next cycle");

   a_cmd_channel: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op != OP_TICK) |=> (rsp_out_channel == $past(req_channel)))
      else $error("answer does not echo the channel");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_ACK || rsp_kind == KIND_QUERY)) |-> rsp_last)
      else $error("acknowledge or query answer without last");

   // reports only come out of a tick walk
   a_report_in_walk: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_FAIL || rsp_kind == KIND_PASS)) |-> $past(busy))
      else $error("report outside a tick walk");

endmodule

bind fault_debounce_table fdt_checker u_fdt_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_op          (req_op),
   .req_channel     (req_channel),
   .rsp_valid       (rsp_valid),
   .rsp_kind        (rsp_kind),
   .rsp_out_channel (rsp_out_channel),
   .rsp_last        (rsp_last)
);

[test/fault_debounce_table_tb.sv]
// fault_debounce_table_tb: self-checking testbench of the fault debounce table
`timescale 1ns / 100ps

module fault_debounce_table_tb;
   import fdt_pkg::*;

   localparam int N_CH = CHANNELS_DEF;
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
   localparam logic [TYPE_W-1:0] TYPE_NONE = 2'd3;
   localparam int PHASE_ITEMS = 58;
   localparam int SETTLE_CYCLES = 100;
   localparam int DRAIN_LIMIT = 20000;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [CH_IN_W-1:0] channel;
      logic [CODE_W-1:0]  vcc_code;
      logic [CODE_W-1:0]  gnd_code;
      logic [CODE_W-1:0]  open_code;
      logic               enable_flag;
      logic [TYPE_W-1:0]  query_type;
   } command_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CH_IN_W-1:0] channel;
      logic [TYPE_W-1:0]  dtype;
      logic               fault_bit;
      logic [TYPES-1:0]   fault_bits;
      logic               intercept;
      logic               last;
   } report_type;

   class debounce_scoreboard;
      logic              global_en;
      logic [TIME_W-1:0] set_time [TYPES];
      logic [TIME_W-1:0] clr_time [TYPES];
      logic [TYPES-1:0]  icpt_mask;
      logic [CODE_W-1:0] codes [N_CH][TYPES];
      logic [TIME_W-1:0] set_cnt [N_CH][TYPES];
      logic [TIME_W-1:0] clr_cnt [N_CH][TYPES];
      logic [TYPES-1:0]  faults [N_CH];
      logic              icpt_flags [N_CH];
      logic              enables [N_CH];
      report_type        expected_reports[$];
      int                errors;

      function new();
         global_en = 1'b1;
         icpt_mask = '0;
         errors = 0;
         for (int t = 0; t < TYPES; t++) begin
            set_time[t] = '0;
            clr_time[t] = '0;
         end
         for (int ch = 0; ch < N_CH; ch++) begin
            clear_channel(ch);
            enables[ch] = (ch != 0);
            for (int t = 0; t < TYPES; t++) begin
               codes[ch][t] = CODE_IDLE;
            end
         end
      endfunction

      function void clear_channel(int ch);
         for (int t = 0; t < TYPES; t++) begin
            set_cnt[ch][t] = '0;
            clr_cnt[ch][t] = '0;
         end
         faults[ch] = '0;
         icpt_flags[ch] = 1'b0;
      endfunction

      function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
         case (idx)
            CFG_GLOBAL_EN: global_en = data[0];
            CFG_VCC_SET:   set_time[TYPE_VCC] = data;
            CFG_VCC_CLR:   clr_time[TYPE_VCC] = data;
            CFG_GND_SET:   set_time[TYPE_GND] = data;
            CFG_GND_CLR:   clr_time[TYPE_GND] = data;
            CFG_OPEN_SET:  set_time[TYPE_OPEN] = data;
            CFG_OPEN_CLR:  clr_time[TYPE_OPEN] = data;
            CFG_MASK:      icpt_mask = data[TYPES-1:0];
            default: ;
         endcase
      endfunction

      function void debounce_tick();
         report_type batch[$];
         report_type r;
         int first;
         logic emit;
         logic failed;
         if (!global_en) return;
         for (int ch = 1; ch < N_CH; ch++) begin
            if (!enables[ch]) continue;
            first = batch.size();
            for (int t = 0; t < TYPES; t++) begin
               emit = 1'b0;
               failed = 1'b0;
               case (codes[ch][t])
                  CODE_POS: begin
                     if (set_cnt[ch][t] < set_time[t]) begin
                        set_cnt[ch][t] = set_cnt[ch][t] + 1'b1;
                     end else begin
                        emit = 1'b1;
                        failed = 1'b1;
                     end
                  end
                  CODE_NEG: begin
                     if (clr_cnt[ch][t] < clr_time[t]) begin
                        clr_cnt[ch][t] = clr_cnt[ch][t] + 1'b1;
                     end else begin
                        emit = 1'b1;
                     end
                  end
                  CODE_SET: begin
                     emit = 1'b1;
                     failed = 1'b1;
                  end
                  CODE_CLR: emit = 1'b1;
                  default: ;
               endcase
               if (emit) begin
                  set_cnt[ch][t] = '0;
                  clr_cnt[ch][t] = '0;
                  faults[ch][t] = failed;
                  r = '0;
                  r.kind = failed ? KIND_FAIL : KIND_PASS;
                  r.channel = CH_IN_W'(ch);
                  r.dtype = TYPE_W'(t);
                  r.fault_bit = failed;
                  batch.push_back(r);
               end
            end
            if ((faults[ch] & icpt_mask) != '0) icpt_flags[ch] = 1'b1;
            for (int k = first; k < batch.size(); k++) begin
               batch[k].fault_bits = faults[ch];
               batch[k].intercept = icpt_flags[ch];
            end
         end
         if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
         foreach (batch[k]) expected_reports.push_back(batch[k]);
      endfunction

      function void note_command(command_type c);
         report_type r;
         logic valid;
         logic [TYPES-1:0] bits;
         valid = int'(c.channel) < N_CH;
         r = '0;
         r.kind = KIND_ACK;
         r.channel = c.channel;
         r.last = 1'b1;
         case (c.op)
            OP_TICK: begin
               debounce_tick();
               return;
            end
            OP_QUERY: begin
               bits = valid ? faults[c.channel] : '0;
               r.kind = KIND_QUERY;
               r.fault_bits = bits;
               r.intercept = valid ? icpt_flags[c.channel] : 1'b0;
               if (c.query_type < TYPES) begin
                  r.dtype = c.query_type;
                  r.fault_bit = bits[c.query_type];
               end else begin
                  r.dtype = TYPE_VCC;
               end
            end
            OP_REPORT: begin
               if (valid) begin
                  codes[c.channel][TYPE_VCC] = c.vcc_code;
                  codes[c.channel][TYPE_GND] = c.gnd_code;
                  codes[c.channel][TYPE_OPEN] = c.open_code;
               end
            end
            OP_ENABLE: if (valid) enables[c.channel] = c.enable_flag;
            OP_CLEAR: if (valid) clear_channel(c.channel);
            OP_CLEAR_ALL: begin
               for (int ch = 0; ch < N_CH; ch++) begin
                  clear_channel(ch);
                  for (int t = 0; t < TYPES; t++) begin
                     codes[ch][t] = CODE_CLR;
                  end
               end
            end
            default: ;
         endcase
         expected_reports.push_back(r);
      endfunction

      function string describe(report_type r);
         return $sformatf("kind %0d ch %0d type %0d bit %0b bits %b icpt %0b last %0b",
                          r.kind, r.channel, r.dtype, r.fault_bit, r.fault_bits,
                          r.intercept, r.last);
      endfunction

      task flag_mismatch(string msg);
         $display("%0t ns: mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_report(report_type got);
         report_type want;
         if (expected_reports.size() == 0) begin
            flag_mismatch({"unexpected result ", describe(got)});
         end else begin
            want = expected_reports.pop_front();
            if (got !== want) begin
               flag_mismatch({"got ", describe(got), ", wanted ", describe(want)});
            end
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [OP_W-1:0]       req_op = OP_TICK;
   logic [CH_IN_W-1:0]    req_channel = '0;
   logic [CODE_W-1:0]     req_open_code = CODE_IDLE;
   logic [CODE_W-1:0]     req_vcc_code = CODE_IDLE;
   logic [CODE_W-1:0]     req_gnd_code = CODE_IDLE;
   logic                  req_enable_flag = 1'b0;
   logic [TYPE_W-1:0]     req_query_type = TYPE_VCC;
   logic                  rsp_valid;
   logic [KIND_W-1:0]     rsp_kind;
   logic [CH_IN_W-1:0]    rsp_out_channel;
   logic [TYPE_W-1:0]     rsp_out_type;
   logic                  rsp_fault_bit;
   logic [TYPES-1:0]      rsp_fault_bits;
   logic                  rsp_intercept;
   logic                  rsp_last;
   logic                  csr_we = 1'b0;
   logic [CFG_IDX_W-1:0]  csr_index = CFG_GLOBAL_EN;
   logic [CFG_DATA_W-1:0] csr_wdata = '0;

   debounce_scoreboard board = new();
   int burst_left = 0;

   fault_debounce_table #(.CHANNELS(N_CH)) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_channel     (req_channel),
      .req_open_code   (req_open_code),
      .req_vcc_code    (req_vcc_code),
      .req_gnd_code    (req_gnd_code),
      .req_enable_flag (req_enable_flag),
      .req_query_type  (req_query_type),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_out_channel (rsp_out_channel),
      .rsp_out_type    (rsp_out_type),
      .rsp_fault_bit   (rsp_fault_bit),
      .rsp_fault_bits  (rsp_fault_bits),
      .rsp_intercept   (rsp_intercept),
      .rsp_last        (rsp_last),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // results first, then the transaction accepted at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            board.check_report(report_type'{rsp_kind, rsp_out_channel, rsp_out_type,
                                            rsp_fault_bit, rsp_fault_bits, rsp_intercept,
                                            rsp_last});
         end
         if (start && !busy) begin
            board.note_command(command_type'{req_op, req_channel, req_vcc_code,
                                             req_gnd_code, req_open_code, req_enable_flag,
                                             req_query_type});
         end
         if (csr_we) board.apply_register(csr_index, csr_wdata);
      end
   end

   function automatic command_type make_command(logic [OP_W-1:0] op, int ch,
                                                logic [CODE_W-1:0] vcc,
                                                logic [CODE_W-1:0] gnd,
                                                logic [CODE_W-1:0] open, logic en,
                                                logic [TYPE_W-1:0] qt);
      command_type c;
      c.op = op;
      c.channel = CH_IN_W'(ch);
      c.vcc_code = vcc;
      c.gnd_code = gnd;
      c.open_code = open;
      c.enable_flag = en;
      c.query_type = qt;
      return c;
   endfunction

   function automatic logic [CODE_W-1:0] random_code();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) return CODE_POS;
      if (pick < 55) return CODE_NEG;
      if (pick < 65) return CODE_SET;
      if (pick < 75) return CODE_CLR;
      if (pick < 95) return CODE_IDLE;
      return CODE_W'($urandom_range(int'(CODE_IDLE) + 1, 7));
   endfunction

   function automatic command_type random_command();
      command_type c;
      int pick;
      c.channel = CH_IN_W'($urandom_range(0, 15));
      c.vcc_code = random_code();
      c.gnd_code = random_code();
      c.open_code = random_code();
      c.enable_flag = $urandom_range(0, 99) < 85;
      c.query_type = TYPE_W'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 36) c.op = OP_TICK;
      else if (pick < 66) c.op = OP_REPORT;
      else if (pick < 80) c.op = OP_QUERY;
      else if (pick < 87) c.op = OP_ENABLE;
      else if (pick < 94) c.op = OP_CLEAR;
      else if (pick < 95) c.op = OP_CLEAR_ALL;
      else if (pick < 96) c.op = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
      else c.op = OP_REPORT;
      return c;
   endfunction

   task automatic put_fields(command_type c);
      req_op <= c.op;
      req_channel <= c.channel;
      req_vcc_code <= c.vcc_code;
      req_gnd_code <= c.gnd_code;
      req_open_code <= c.open_code;
      req_enable_flag <= c.enable_flag;
      req_query_type <= c.query_type;
   endtask

   task automatic send_command(command_type c);
      int gap;
      if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else begin
         gap = $urandom_range(0, 17);
         if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(4, 24);
      end
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         put_fields(random_command());
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      put_fields(c);
      do @(posedge clock); while (busy);
   endtask

   task automatic csr_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(logic en, int time_lo, int time_hi, logic [TYPES-1:0] mask);
      csr_write(CFG_GLOBAL_EN, {7'd0, en});
      csr_write(CFG_VCC_SET, CFG_DATA_W'($urandom_range(time_lo, time_hi)));
      csr_write(CFG_VCC_CLR, CFG_DATA_W'($urandom_range(time_lo, time_hi)));
      csr_write(CFG_GND_SET, CFG_DATA_W'($urandom_range(time_lo, time_hi)));
      csr_write(CFG_GND_CLR, CFG_DATA_W'($urandom_range(time_lo, time_hi)));
      csr_write(CFG_OPEN_SET, CFG_DATA_W'($urandom_range(time_lo, time_hi)));
      csr_write(CFG_OPEN_CLR, CFG_DATA_W'($urandom_range(time_lo, time_hi)));
      csr_write(CFG_MASK, {5'd0, mask});
   endtask

   task automatic drain_results();
      int guard;
      guard = 0;
      @(negedge clock);
      start <= 1'b0;
      while (board.expected_reports.size() > 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      command_type directed[$];
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: every time zero, mask clear, tick enabled
      directed.push_back(make_command(OP_QUERY, 0, CODE_IDLE, CODE_IDLE, CODE_IDLE, 1'b0,
                                      TYPE_VCC));
      directed.push_back(make_command(OP_QUERY, 15, CODE_IDLE, CODE_IDLE, CODE_IDLE, 1'b1,
                                      TYPE_NONE));
      directed.push_back(make_command(OP_REPORT, 0, CODE_SET, CODE_SET, CODE_SET, 1'b0,
                                      TYPE_VCC));
      directed.push_back(make_command(OP_ENABLE, 0, CODE_IDLE, CODE_IDLE, CODE_IDLE, 1'b1,
                                      TYPE_VCC));
      directed.push_back(make_command(OP_REPORT, 1, CODE_SET, CODE_SET, CODE_SET, 1'b0,
                                      TYPE_VCC));
      directed.push_back(make_command(OP_REPORT, 2, CODE_POS, CODE_NEG, CODE_CLR, 1'b0,
                                      TYPE_VCC));
      directed.push_back(make_command(OP_REPORT, 15, CODE_IDLE + 3'd1, CODE_IDLE + 3'd2,
                                      CODE_IDLE + 3'd3, 1'b1, TYPE_NONE));
      directed.push_back(make_command(OP_ENABLE, 3, CODE_IDLE, CODE_IDLE, CODE_IDLE, 1'b0,
                                      TYPE_VCC));
      directed.push_back(make_command(OP_REPORT, 3, CODE_SET, CODE_SET, CODE_SET, 1'b0,
                                      TYPE_VCC));
      directed.push_back(make_command(OP_TICK, 0, CODE_IDLE, CODE_IDLE, CODE_IDLE, 1'b0,
                                      TYPE_VCC));
      directed.push_back(make_command(OP_QUERY, 1, CODE_IDLE, CODE_IDLE, CODE_IDLE, 1'b0,
                                      TYPE_OPEN));
      directed.push_back(make_command(OP_QUERY, 3, CODE_IDLE, CODE_IDLE, CODE_IDLE, 1'b0,
                                      TYPE_GND));
      directed.push_back(make_command(OP_CLEAR, 1, CODE_IDLE, CODE_IDLE, CODE_IDLE, 1'b0,
                                      TYPE_VCC));
      directed.push_back(make_command(OP_QUERY, 1, CODE_IDLE, CODE_IDLE, CODE_IDLE, 1'b0,
                                      TYPE_VCC));
      directed.push_back(make_command(OP_SPARE_LO, 4, CODE_CLR, CODE_CLR, CODE_CLR, 1'b0,
                                      TYPE_GND));
      directed.push_back(make_command(OP_SPARE_HI, 15, 3'd7, 3'd7, 3'd7, 1'b1, TYPE_NONE));
      directed.push_back(make_command(OP_TICK, 15, CODE_IDLE, CODE_IDLE, CODE_IDLE, 1'b1,
                                      TYPE_NONE));
      directed.push_back(make_command(OP_ENABLE, 3, CODE_IDLE, CODE_IDLE, CODE_IDLE, 1'b1,
                                      TYPE_VCC));
      directed.push_back(make_command(OP_CLEAR_ALL, 7, CODE_IDLE, CODE_IDLE, CODE_IDLE, 1'b0,
                                      TYPE_VCC));
      directed.push_back(make_command(OP_TICK, 0, CODE_IDLE, CODE_IDLE, CODE_IDLE, 1'b0,
                                      TYPE_VCC));
      directed.push_back(make_command(OP_QUERY, 2, CODE_IDLE, CODE_IDLE, CODE_IDLE, 1'b0,
                                      TYPE_OPEN));
      directed.push_back(make_command(OP_REPORT, 5, CODE_IDLE, CODE_IDLE, CODE_IDLE, 1'b0,
                                      TYPE_VCC));
      directed.push_back(make_command(OP_ENABLE, 6, CODE_IDLE, CODE_IDLE, CODE_IDLE, 1'b0,
                                      TYPE_VCC));
      directed.push_back(make_command(OP_TICK, 0, CODE_IDLE, CODE_IDLE, CODE_IDLE, 1'b0,
                                      TYPE_VCC));
      directed.push_back(make_command(OP_CLEAR, 15, CODE_IDLE, CODE_IDLE, CODE_IDLE, 1'b1,
                                      TYPE_NONE));
      foreach (directed[i]) send_command(directed[i]);

      for (int p = 0; p < 6; p++) begin
         drain_results();
         case (p)
            0: configure(1'b1, 0, 3, TYPES'($urandom_range(0, 7)));
            1: configure(1'b1, 0, 0, 3'b111);
            2: configure(1'b1, 255, 255, TYPES'($urandom_range(0, 7)));
            3: configure(1'b0, 0, 3, 3'b111);
            4: configure(1'b1, 0, 7, TYPES'($urandom_range(0, 7)));
            default: configure(1'b1, 0, 255, 3'b000);
         endcase
         repeat (PHASE_ITEMS) send_command(random_command());
      end

      drain_results();
      if (board.expected_reports.size() > 0) begin
         board.flag_mismatch($sformatf("%0d results never arrived",
                                       board.expected_reports.size()));
      end
      if (board.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
